>>> rtl/mvfm_pkg.sv
// Shared types and constants of the motion velocity fusion monitor.
package mvfm_pkg;

    localparam int FRAC_BITS = 8;

    localparam int MODE_W     = 2;
    localparam int S_DATA_W   = 128;
    localparam int M_DATA_W   = 56;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;

    localparam int DIV_N_W   = 65;
    localparam int DIV_D_W   = 48;
    localparam int DIV_CNT_W = 7;

    localparam logic [1:0] MODE_ACCEL   = 2'd0;
    localparam logic [1:0] MODE_CHECK   = 2'd1;
    localparam logic [1:0] MODE_RESTART = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FAST = 2'd1;
    localparam logic [1:0] ST_SLOW = 2'd2;

    localparam logic [0:0] KIND_CHECK   = 1'b0;
    localparam logic [0:0] KIND_RESTART = 1'b1;

    localparam logic [2:0] REG_DIRECTION  = 3'd0;
    localparam logic [2:0] REG_GRAVITY    = 3'd1;
    localparam logic [2:0] REG_MM_PER_TCK = 3'd2;
    localparam logic [2:0] REG_ACC_SCALE  = 3'd3;
    localparam logic [2:0] REG_MIN_SPEED  = 3'd4;
    localparam logic [2:0] REG_THRESHOLD  = 3'd5;
    localparam logic [2:0] REG_HPF_ALPHA  = 3'd6;
    localparam logic [2:0] REG_ENC_WEIGHT = 3'd7;

    typedef enum logic [14:0] {
        S_IDLE        = 15'h0001,
        S_ENC_MUL     = 15'h0002,
        S_ENC_DIV_LD  = 15'h0004,
        S_ENC_DIV     = 15'h0008,
        S_MEAN_DIV_LD = 15'h0010,
        S_MEAN_DIV    = 15'h0020,
        S_HPF_MUL     = 15'h0040,
        S_HPF_SAT     = 15'h0080,
        S_SCALE_MUL   = 15'h0100,
        S_INTEG       = 15'h0200,
        S_BLEND_MUL   = 15'h0400,
        S_BLEND_SUM   = 15'h0800,
        S_STATUS_MUL  = 15'h1000,
        S_STATUS_FIN  = 15'h2000,
        S_EMIT        = 15'h4000
    } state_t;

    typedef struct packed {
        logic accel_add;
        logic restart;
        logic rebase_in;
        logic check_load;
        logic enc_mul;
        logic enc_div_start;
        logic enc_div_take;
        logic mean_div_start;
        logic mean_div_take;
        logic hpf_mul;
        logic hpf_sat;
        logic scale_mul;
        logic integ_step;
        logic blend_mul;
        logic blend_sum;
        logic status_mul;
        logic status_fin;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic running;
        logic window_nz;
        logic dt_pos;
        logic div_done;
        logic integ_last;
        logic out_free;
    } stat_t;

endpackage

>>> rtl/motion_velocity_fusion_monitor_top.sv
// Top level of the motion velocity fusion monitor.
//
// The input stream carries accelerometer samples, check ticks and restarts,
// selected by s_tuser. Accelerometer samples and ignored items are absorbed
// while the controller is idle and give no result. A restart gives one
// acknowledgement transaction, held back by any output stall. A check tick
// that runs through the fusion passes twice through a one-bit-per-cycle
// divider of 65 steps each (encoder speed, window mean) and through a 48-step
// serial multiplication of the filtered acceleration by the time step, besides
// the load, multiply, filter, blend and status steps. One item is in work at a
// time; s_tready is high only while the controller is idle.
// Results leave through an output register. When the receiver stalls, a
// finished result waits in the last state until the register frees up.
// A synchronous low aresetn restores the configuration and state registers to
// their defaults, stops the monitor until the next restart and drops any
// pending result. Configuration is written through cfg_wr_en, cfg_addr and
// cfg_wr_data, by the user only while the block is idle; the block does not enforce it.
module motion_velocity_fusion_monitor_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // accel_y[15:0], wheel_left_count[47:16], wheel_right_count[79:48], now_ms[127:80]
    input  logic [mvfm_pkg::S_DATA_W-1:0]     s_tdata,
    // mode[1:0]
    input  logic [mvfm_pkg::MODE_W-1:0]       s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // motion_status[1:0], status_changed[2], encoder_velocity[26:3],
    // fused_velocity[50:27], zero padding above
    output logic [mvfm_pkg::M_DATA_W-1:0]     m_tdata,
    // kind[0]
    output logic [0:0]                        m_tuser,
    input  logic                              cfg_wr_en,
    input  logic [mvfm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [mvfm_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);

    mvfm_pkg::cmd_t  cmd;
    mvfm_pkg::stat_t stat;

    mvfm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mvfm_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .stat        (stat),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

>>> rtl/mvfm_div.sv
// Restoring divider that produces one quotient bit per cycle.
module mvfm_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [mvfm_pkg::DIV_N_W-1:0]  dividend,
    input  logic [mvfm_pkg::DIV_D_W-1:0]  divisor,
    output logic [mvfm_pkg::DIV_N_W-1:0]  quotient,
    output logic                          done
);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [mvfm_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [mvfm_pkg::DIV_D_W-1:0]    rem_reg, rem_next;
    logic [mvfm_pkg::DIV_D_W-1:0]    dsr_reg, dsr_next;
    logic [mvfm_pkg::DIV_N_W-1:0]    quo_reg, quo_next;
    logic [mvfm_pkg::DIV_D_W:0]      rem_sh;
    logic [mvfm_pkg::DIV_D_W:0]      rem_sub;
    logic                            ge;

    assign rem_sh  = {rem_reg, quo_reg[mvfm_pkg::DIV_N_W-1]};
    assign ge      = rem_sh >= {1'b0, dsr_reg};
    assign rem_sub = rem_sh - {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = mvfm_pkg::DIV_CNT_W'(mvfm_pkg::DIV_N_W - 1);
            rem_next  = '0;
            dsr_next  = divisor;
            quo_next  = dividend;
        end else if (busy_reg) begin
            rem_next = ge ? rem_sub[mvfm_pkg::DIV_D_W-1:0] : rem_sh[mvfm_pkg::DIV_D_W-1:0];
            quo_next = {quo_reg[mvfm_pkg::DIV_N_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

>>> rtl/mvfm_ctrl.sv
// Controller state machine that sequences the fusion datapath.
module mvfm_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic [mvfm_pkg::MODE_W-1:0]   s_tuser,
    output logic                          s_tready,
    input  mvfm_pkg::stat_t               stat,
    output mvfm_pkg::cmd_t                cmd
);

    mvfm_pkg::state_t state_reg, state_next;

    assign s_tready = (state_reg == mvfm_pkg::S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            mvfm_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    unique case (s_tuser)
                        mvfm_pkg::MODE_ACCEL: begin
                            cmd.accel_add = 1'b1;
                        end
                        mvfm_pkg::MODE_RESTART: begin
                            cmd.restart = 1'b1;
                            state_next  = mvfm_pkg::S_EMIT;
                        end
                        mvfm_pkg::MODE_CHECK: begin
                            if (stat.running && stat.window_nz) begin
                                if (stat.dt_pos) begin
                                    cmd.check_load = 1'b1;
                                    state_next     = mvfm_pkg::S_ENC_MUL;
                                end else begin
                                    cmd.rebase_in = 1'b1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            mvfm_pkg::S_ENC_MUL: begin
                cmd.enc_mul = 1'b1;
                state_next  = mvfm_pkg::S_ENC_DIV_LD;
            end
            mvfm_pkg::S_ENC_DIV_LD: begin
                cmd.enc_div_start = 1'b1;
                state_next        = mvfm_pkg::S_ENC_DIV;
            end
            mvfm_pkg::S_ENC_DIV: begin
                if (stat.div_done) begin
                    cmd.enc_div_take = 1'b1;
                    state_next       = mvfm_pkg::S_MEAN_DIV_LD;
                end
            end
            mvfm_pkg::S_MEAN_DIV_LD: begin
                cmd.mean_div_start = 1'b1;
                state_next         = mvfm_pkg::S_MEAN_DIV;
            end
            mvfm_pkg::S_MEAN_DIV: begin
                if (stat.div_done) begin
                    cmd.mean_div_take = 1'b1;
                    state_next        = mvfm_pkg::S_HPF_MUL;
                end
            end
            mvfm_pkg::S_HPF_MUL: begin
                cmd.hpf_mul = 1'b1;
                state_next  = mvfm_pkg::S_HPF_SAT;
            end
            mvfm_pkg::S_HPF_SAT: begin
                cmd.hpf_sat = 1'b1;
                state_next  = mvfm_pkg::S_SCALE_MUL;
            end
            mvfm_pkg::S_SCALE_MUL: begin
                cmd.scale_mul = 1'b1;
                state_next    = mvfm_pkg::S_INTEG;
            end
            mvfm_pkg::S_INTEG: begin
                cmd.integ_step = 1'b1;
                if (stat.integ_last) begin
                    state_next = mvfm_pkg::S_BLEND_MUL;
                end
            end
            mvfm_pkg::S_BLEND_MUL: begin
                cmd.blend_mul = 1'b1;
                state_next    = mvfm_pkg::S_BLEND_SUM;
            end
            mvfm_pkg::S_BLEND_SUM: begin
                cmd.blend_sum = 1'b1;
                state_next    = mvfm_pkg::S_STATUS_MUL;
            end
            mvfm_pkg::S_STATUS_MUL: begin
                cmd.status_mul = 1'b1;
                state_next     = mvfm_pkg::S_STATUS_FIN;
            end
            mvfm_pkg::S_STATUS_FIN: begin
                cmd.status_fin = 1'b1;
                state_next     = mvfm_pkg::S_EMIT;
            end
            mvfm_pkg::S_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = mvfm_pkg::S_IDLE;
                end
            end
            default: state_next = mvfm_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mvfm_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/mvfm_dp.sv
// Datapath: configuration, filter state, arithmetic steps and the result register.
module mvfm_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [mvfm_pkg::S_DATA_W-1:0]     s_tdata,
    input  logic                              cfg_wr_en,
    input  logic [mvfm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [mvfm_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input  mvfm_pkg::cmd_t                    cmd,
    output mvfm_pkg::stat_t                   stat,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mvfm_pkg::M_DATA_W-1:0]     m_tdata,
    output logic [0:0]                        m_tuser
);

    localparam int F = mvfm_pkg::FRAC_BITS;

    // Configuration registers.
    logic        dir_reg;
    logic [15:0] grav_reg;
    logic [23:0] mm_reg;
    logic [15:0] scale_reg;
    logic [11:0] min_reg;
    logic [6:0]  thr_reg;
    logic [14:0] alpha_reg;
    logic [15:0] weight_reg;

    // Block state.
    logic               running_reg;
    logic [31:0]        left_base_reg, right_base_reg;
    logic [47:0]        last_ms_reg;
    logic signed [31:0] wsum_reg;
    logic [15:0]        wcnt_reg;
    logic signed [23:0] fspeed_reg;
    logic signed [23:0] prev_in_reg;
    logic signed [31:0] prev_out_reg;
    logic [1:0]         cur_st_reg;

    // Per-check working registers.
    logic [31:0]        left_in_reg, right_in_reg;
    logic [47:0]        now_reg, dt_reg, dtsh_reg;
    logic [31:0]        tick_mag_reg;
    logic               tneg_reg;
    logic [55:0]        travel_reg;
    logic signed [23:0] venc_reg, mean_reg, fused_reg;
    logic signed [49:0] hprod_reg;
    logic [47:0]        p_reg;
    logic [52:0]        acc_reg;
    logic               acc_sat_reg;
    logic [5:0]         icnt_reg;
    logic signed [45:0] pa_reg, pb_reg;
    logic signed [32:0] lhs_reg;
    logic [30:0]        rhs_reg;
    logic               low_reg;
    logic [0:0]         res_kind_reg;
    logic [1:0]         res_st_reg;
    logic               res_chg_reg;

    // Result register.
    logic               out_valid_reg;
    logic [0:0]         out_kind_reg;
    logic [1:0]         out_st_reg;
    logic               out_chg_reg;
    logic [23:0]        out_venc_reg, out_fused_reg;

    logic [15:0] in_accel;
    logic [31:0] in_left, in_right;
    logic [47:0] in_now;
    assign in_accel = s_tdata[15:0];
    assign in_left  = s_tdata[47:16];
    assign in_right = s_tdata[79:48];
    assign in_now   = s_tdata[127:80];

    // Time step and encoder travel of the incoming check.
    logic [48:0]        dt_diff;
    logic [31:0]        dl, dr;
    logic signed [32:0] tsum;
    logic [32:0]        tsum_mag;
    assign dt_diff  = {1'b0, in_now} - {1'b0, last_ms_reg};
    assign dl       = in_left - left_base_reg;
    assign dr       = in_right - right_base_reg;
    assign tsum     = $signed({dl[31], dl}) + $signed({dr[31], dr});
    assign tsum_mag = tsum[32] ? 33'd0 - tsum : tsum;

    // Divider operands and results.
    logic                          div_start, div_done;
    logic [mvfm_pkg::DIV_N_W-1:0]  div_n, div_q;
    logic [mvfm_pkg::DIV_D_W-1:0]  div_d;
    logic [65:0]                   travel_k;
    logic [31:0]                   sum_mag;
    assign travel_k  = ({10'd0, travel_reg} << 10) - ({10'd0, travel_reg} << 4)
                     - ({10'd0, travel_reg} << 3);
    assign sum_mag   = wsum_reg[31] ? 32'd0 - wsum_reg : wsum_reg;
    assign div_start = cmd.enc_div_start || cmd.mean_div_start;
    assign div_n     = cmd.enc_div_start ? travel_k[mvfm_pkg::DIV_N_W-1:0]
                                         : (mvfm_pkg::DIV_N_W'(sum_mag) << F);
    assign div_d     = cmd.enc_div_start ? dt_reg : mvfm_pkg::DIV_D_W'(wcnt_reg);

    mvfm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .quotient (div_q),
        .done     (div_done)
    );

    // Encoder velocity from the quotient.
    logic [mvfm_pkg::DIV_N_W-1:0] vm_full;
    logic [23:0]                  vm;
    logic [24:0]                  vm_neg;
    logic                         vneg;
    logic [23:0]                  venc_next;
    assign vm_full   = div_q >> (16 - F);
    assign vm        = (vm_full > mvfm_pkg::DIV_N_W'(24'h800000)) ? 24'h800000 : vm_full[23:0];
    assign vm_neg    = 25'd0 - {1'b0, vm};
    assign vneg      = tneg_reg != dir_reg;
    assign venc_next = vneg ? vm_neg[23:0] : (vm[23] ? 24'h7FFFFF : vm);

    // Window mean from the quotient.
    logic [23:0] mean_next;
    always_comb begin
        if (!wsum_reg[31]) begin
            mean_next = (div_q > mvfm_pkg::DIV_N_W'(24'h7FFFFF)) ? 24'h7FFFFF : div_q[23:0];
        end else begin
            mean_next = (div_q > mvfm_pkg::DIV_N_W'(24'h800000)) ? 24'h800000
                                                                  : 24'd0 - div_q[23:0];
        end
    end

    // High-pass filter.
    logic signed [33:0] hx;
    logic signed [15:0] alpha_s;
    logic signed [49:0] hprod_next;
    logic [49:0]        hmag;
    logic [34:0]        hsh;
    logic [31:0]        hy_next;
    assign hx         = 34'(prev_out_reg) + 34'(mean_reg) - 34'(prev_in_reg);
    assign alpha_s    = $signed({1'b0, alpha_reg});
    assign hprod_next = hx * alpha_s;
    assign hmag       = hprod_reg[49] ? 50'd0 - hprod_reg : hprod_reg;
    assign hsh        = hmag[49:15];
    always_comb begin
        if (!hprod_reg[49]) begin
            hy_next = (hsh > 35'h07FFFFFFF) ? 32'h7FFFFFFF : hsh[31:0];
        end else begin
            hy_next = (hsh > 35'h080000000) ? 32'h80000000 : 32'd0 - hsh[31:0];
        end
    end

    // Integration of the filtered acceleration over the time step.
    logic [31:0] hy_mag;
    logic [52:0] acc_next;
    logic [26:0] dvm;
    logic [27:0] dvm_s;
    logic signed [27:0] vacc;
    assign hy_mag   = prev_out_reg[31] ? 32'd0 - prev_out_reg : prev_out_reg;
    assign acc_next = {acc_reg[51:0], 1'b0} + (dtsh_reg[47] ? {5'd0, p_reg} : 53'd0);
    assign dvm      = (acc_sat_reg || (acc_reg[50:24] > 27'h4000000)) ? 27'h4000000
                                                                      : acc_reg[50:24];
    assign dvm_s    = prev_out_reg[31] ? 28'd0 - {1'b0, dvm} : {1'b0, dvm};
    assign vacc     = 28'(fspeed_reg) + $signed(dvm_s);

    // Blend.
    logic [15:0]        w_lim, wc;
    logic signed [16:0] w_s, wc_s;
    logic signed [45:0] pa_next, pb_next, blend;
    logic [45:0]        bmag;
    logic [30:0]        bsh;
    logic [23:0]        fused_next;
    assign w_lim   = (weight_reg > 16'h8000) ? 16'h8000 : weight_reg;
    assign wc      = 16'h8000 - w_lim;
    assign w_s     = $signed({1'b0, w_lim});
    assign wc_s    = $signed({1'b0, wc});
    assign pa_next = w_s * venc_reg;
    assign pb_next = wc_s * vacc;
    assign blend   = pa_reg + pb_reg;
    assign bmag    = blend[45] ? 46'd0 - blend : blend;
    assign bsh     = bmag[45:15];
    always_comb begin
        if (!blend[45]) begin
            fused_next = (bsh > 31'h007FFFFF) ? 24'h7FFFFF : bsh[23:0];
        end else begin
            fused_next = (bsh > 31'h00800000) ? 24'h800000 : 24'd0 - bsh[23:0];
        end
    end

    // Classification.
    logic [23:0]        venc_mag;
    logic signed [24:0] vdiff;
    logic signed [32:0] lhs_next;
    logic signed [32:0] rhs_s;
    logic [1:0]         st_next;
    assign venc_mag = venc_reg[23] ? 24'd0 - venc_reg : venc_reg;
    assign vdiff    = 25'(fused_reg) - 25'(venc_reg);
    assign lhs_next = vdiff * 33'sd100;
    assign rhs_s    = $signed({2'b0, rhs_reg});
    always_comb begin
        if (low_reg) begin
            st_next = mvfm_pkg::ST_OK;
        end else if (lhs_reg > rhs_s) begin
            st_next = mvfm_pkg::ST_FAST;
        end else if (lhs_reg < -rhs_s) begin
            st_next = mvfm_pkg::ST_SLOW;
        end else begin
            st_next = mvfm_pkg::ST_OK;
        end
    end

    // Gravity seed of the filter input.
    logic signed [63:0] grav_sh;
    logic [23:0]        seed;
    assign grav_sh = {{48{grav_reg[15]}}, grav_reg} <<< F;
    assign seed    = (grav_sh > 64'sd8388607)  ? 24'h7FFFFF :
                     (grav_sh < -64'sd8388608) ? 24'h800000 : grav_sh[23:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_reg        <= 1'b0;
            grav_reg       <= 16'd0;
            mm_reg         <= 24'd65536;
            scale_reg      <= 16'd10033;
            min_reg        <= 12'd50;
            thr_reg        <= 7'd5;
            alpha_reg      <= 15'd31130;
            weight_reg     <= 16'd27853;
            running_reg    <= 1'b0;
            left_base_reg  <= '0;
            right_base_reg <= '0;
            last_ms_reg    <= '0;
            wsum_reg       <= '0;
            wcnt_reg       <= '0;
            fspeed_reg     <= '0;
            prev_in_reg    <= '0;
            prev_out_reg   <= '0;
            cur_st_reg     <= mvfm_pkg::ST_OK;
            out_valid_reg  <= 1'b0;
            acc_sat_reg    <= 1'b0;
            icnt_reg       <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    mvfm_pkg::REG_DIRECTION:  dir_reg    <= cfg_wr_data[0];
                    mvfm_pkg::REG_GRAVITY:    grav_reg   <= cfg_wr_data[15:0];
                    mvfm_pkg::REG_MM_PER_TCK: mm_reg     <= cfg_wr_data;
                    mvfm_pkg::REG_ACC_SCALE:  scale_reg  <= cfg_wr_data[15:0];
                    mvfm_pkg::REG_MIN_SPEED:  min_reg    <= cfg_wr_data[11:0];
                    mvfm_pkg::REG_THRESHOLD:  thr_reg    <= cfg_wr_data[6:0];
                    mvfm_pkg::REG_HPF_ALPHA:  alpha_reg  <= cfg_wr_data[14:0];
                    mvfm_pkg::REG_ENC_WEIGHT: weight_reg <= cfg_wr_data[15:0];
                    default: ;
                endcase
            end
            if (cmd.accel_add && running_reg && (wcnt_reg != 16'hFFFF)) begin
                wsum_reg <= wsum_reg + 32'(signed'(in_accel));
                wcnt_reg <= wcnt_reg + 16'd1;
            end
            if (cmd.restart || cmd.rebase_in) begin
                left_base_reg  <= in_left;
                right_base_reg <= in_right;
                last_ms_reg    <= in_now;
                wsum_reg       <= '0;
                wcnt_reg       <= '0;
            end
            if (cmd.restart) begin
                running_reg  <= 1'b1;
                fspeed_reg   <= '0;
                prev_in_reg  <= seed;
                prev_out_reg <= '0;
                cur_st_reg   <= mvfm_pkg::ST_OK;
            end
            if (cmd.hpf_sat) begin
                prev_in_reg  <= mean_reg;
                prev_out_reg <= hy_next;
            end
            if (cmd.scale_mul) begin
                acc_sat_reg <= 1'b0;
                icnt_reg    <= 6'd47;
            end
            if (cmd.integ_step) begin
                icnt_reg <= icnt_reg - 6'd1;
                if (!acc_sat_reg && (acc_next[52:51] != 2'd0)) begin
                    acc_sat_reg <= 1'b1;
                end
            end
            if (cmd.blend_sum) begin
                fspeed_reg     <= fused_next;
                left_base_reg  <= left_in_reg;
                right_base_reg <= right_in_reg;
                last_ms_reg    <= now_reg;
                wsum_reg       <= '0;
                wcnt_reg       <= '0;
            end
            if (cmd.status_fin) begin
                cur_st_reg <= st_next;
                if (low_reg) begin
                    fspeed_reg <= '0;
                end
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end

        if (cmd.check_load) begin
            left_in_reg  <= in_left;
            right_in_reg <= in_right;
            now_reg      <= in_now;
            dt_reg       <= dt_diff[47:0];
            tick_mag_reg <= tsum_mag[32:1];
            tneg_reg     <= tsum[32] && (tsum_mag[32:1] != 32'd0);
        end
        if (cmd.enc_mul) begin
            travel_reg <= {24'd0, tick_mag_reg} * {32'd0, mm_reg};
        end
        if (cmd.enc_div_take) begin
            venc_reg <= venc_next;
        end
        if (cmd.mean_div_take) begin
            mean_reg <= mean_next;
        end
        if (cmd.hpf_mul) begin
            hprod_reg <= hprod_next;
        end
        if (cmd.scale_mul) begin
            p_reg    <= {16'd0, hy_mag} * {32'd0, scale_reg};
            acc_reg  <= '0;
            dtsh_reg <= dt_reg;
        end
        if (cmd.integ_step) begin
            if (!acc_sat_reg) begin
                acc_reg <= acc_next;
            end
            dtsh_reg <= {dtsh_reg[46:0], 1'b0};
        end
        if (cmd.blend_mul) begin
            pa_reg <= pa_next;
            pb_reg <= pb_next;
        end
        if (cmd.blend_sum) begin
            fused_reg <= fused_next;
        end
        if (cmd.status_mul) begin
            lhs_reg <= lhs_next;
            rhs_reg <= {24'd0, thr_reg} * {7'd0, venc_mag};
            low_reg <= 32'(venc_mag) < (32'(min_reg) << F);
        end
        if (cmd.status_fin) begin
            res_kind_reg <= mvfm_pkg::KIND_CHECK;
            res_st_reg   <= st_next;
            res_chg_reg  <= st_next != cur_st_reg;
        end
        if (cmd.restart) begin
            res_kind_reg <= mvfm_pkg::KIND_RESTART;
            res_st_reg   <= mvfm_pkg::ST_OK;
            res_chg_reg  <= cur_st_reg != mvfm_pkg::ST_OK;
            venc_reg     <= '0;
            fused_reg    <= '0;
        end
        if (cmd.emit) begin
            out_kind_reg  <= res_kind_reg;
            out_st_reg    <= res_st_reg;
            out_chg_reg   <= res_chg_reg;
            out_venc_reg  <= venc_reg;
            out_fused_reg <= fused_reg;
        end
    end

    assign stat.running    = running_reg;
    assign stat.window_nz  = wcnt_reg != 16'd0;
    assign stat.dt_pos     = !dt_diff[48] && (dt_diff != 49'd0);
    assign stat.div_done   = div_done;
    assign stat.integ_last = icnt_reg == 6'd0;
    assign stat.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {5'd0, out_fused_reg, out_venc_reg, out_chg_reg, out_st_reg};

endmodule

>>> rtl/mvfm_checker.sv
// Port-level checker of the motion velocity fusion monitor and its bind.
module mvfm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [0:0]  m_tuser
);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_restart_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[1:0] == mvfm_pkg::ST_OK && m_tdata[55:3] == 53'd0)
        else $error("restart acknowledgement carries nonzero status or velocity");

    a_restart_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == mvfm_pkg::MODE_RESTART |=> !s_tready)
        else $error("input taken while a restart acknowledgement is pending");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[1:0] != 2'd3)
        else $error("undefined motion status reported");

endmodule

bind motion_velocity_fusion_monitor_top mvfm_checker u_mvfm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
